@@ rtl/core/hcd_pkg.sv @@
package hcd_pkg;

  localparam int STORE_DEPTH = 8;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int COUNT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [3:0] NIB_ZERO = 4'h0;
  localparam logic [3:0] NIB_FULL = 4'hf;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Length codes that select a color layout
  localparam logic [COUNT_W-1:0] LEN_RGB = 4'd3;
  localparam logic [COUNT_W-1:0] LEN_RGBA = 4'd4;
  localparam logic [COUNT_W-1:0] LEN_RRGGBB = 4'd6;
  localparam logic [COUNT_W-1:0] LEN_RRGGBBAA = 4'd8;

  // Classified character: valid flag plus nibble value
  typedef struct packed {
    logic       hex;
    logic [3:0] val;
  } hcd_digit_t;

  // One queue entry from front to back
  typedef struct packed {
    logic       cnt;
    hcd_digit_t digit;
    logic       last;
    logic       ok;
  } hcd_entry_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } hcd_result_t;

  function automatic hcd_digit_t hcd_classify(input logic [7:0] c);
    hcd_digit_t d;
    d.hex = 1'b0;
    d.val = NIB_ZERO;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.hex = 1'b1;
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.hex = 1'b1;
      d.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.hex = 1'b1;
      d.val = 4'(c - 8'h57);
    end
    return d;
  endfunction

  function automatic logic [3:0] hcd_nibble(input hcd_digit_t d, input logic is_alpha);
    logic [3:0] n;
    if (d.hex) begin
      n = d.val;
    end else begin
      n = is_alpha ? NIB_FULL : NIB_ZERO;
    end
    return n;
  endfunction

endpackage

@@ rtl/core/hcd_front.sv @@
module hcd_front import hcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] ch,
  input  logic       has_char,
  input  logic       last,
  output logic       push,
  output hcd_entry_t entry
);

  logic at_start_r;
  logic at_start_nxt;
  logic is_hash;

  // Classify the character and decide whether it counts
  always_comb begin
    is_hash = at_start_r && (ch == CH_HASH);
    entry.cnt = has_char && !is_hash;
    entry.digit = hcd_classify(ch);
    entry.last = last;
    entry.ok = !at_start_r || has_char;
    push = acc && (entry.cnt || last);
  end

  // Track start of string
  always_comb begin
    at_start_nxt = at_start_r;
    if (acc) begin
      if (last) begin
        at_start_nxt = 1'b1;
      end else if (has_char) begin
        at_start_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else begin
      at_start_r <= at_start_nxt;
    end
  end

endmodule

@@ rtl/core/hcd_queue.sv @@
module hcd_queue import hcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hcd_entry_t push_entry,
  input  logic       pop,
  output logic       q_valid,
  output hcd_entry_t q_entry,
  output logic       full
);

  hcd_entry_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;

  // Write the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_nxt;
    end
  end

  assign q_valid = (fill_r != 2'd0);
  assign q_entry = mem_r[rd_ptr_r];
  assign full = (fill_r == 2'd2);

endmodule

@@ rtl/core/hcd_back.sv @@
module hcd_back import hcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  hcd_entry_t  q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output hcd_result_t res
);

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  hcd_digit_t         store_r [STORE_DEPTH];
  hcd_digit_t         store_nxt [STORE_DEPTH];
  logic               wr_en;
  logic               out_valid_r;
  hcd_result_t        res_r;
  hcd_result_t        res_nxt;
  logic               emit;

  // Pop unless a finishing item meets a full, stalled output
  assign pop = q_valid && (!q_entry.last || !out_valid_r || !out_stall);
  assign emit = pop && q_entry.last;
  assign wr_en = pop && q_entry.cnt && !count_r[COUNT_W-1];

  // Count digits, saturating
  always_comb begin
    count_nxt = count_r;
    if (pop && q_entry.cnt && count_r != COUNT_MAX) begin
      count_nxt = count_r + 4'd1;
    end
  end

  // Store view including the digit arriving now
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (wr_en) begin
      store_nxt[count_r[STORE_IDX_W-1:0]] = q_entry.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r[STORE_IDX_W-1:0]] <= q_entry.digit;
    end
  end

  // Decode the color from the stored digits
  always_comb begin
    res_nxt.ok = q_entry.ok;
    res_nxt.red = 8'h00;
    res_nxt.green = 8'h00;
    res_nxt.blue = 8'h00;
    res_nxt.alpha = ALPHA_OPAQUE;
    if (!q_entry.ok) begin
      res_nxt.alpha = 8'h00;
    end else if (count_nxt == LEN_RGB || count_nxt == LEN_RGBA) begin
      res_nxt.red = {2{hcd_nibble(store_nxt[0], 1'b0)}};
      res_nxt.green = {2{hcd_nibble(store_nxt[1], 1'b0)}};
      res_nxt.blue = {2{hcd_nibble(store_nxt[2], 1'b0)}};
      if (count_nxt == LEN_RGBA) begin
        res_nxt.alpha = {2{hcd_nibble(store_nxt[3], 1'b1)}};
      end
    end else if (count_nxt == LEN_RRGGBB || count_nxt == LEN_RRGGBBAA) begin
      res_nxt.red = {hcd_nibble(store_nxt[0], 1'b0), hcd_nibble(store_nxt[1], 1'b0)};
      res_nxt.green = {hcd_nibble(store_nxt[2], 1'b0), hcd_nibble(store_nxt[3], 1'b0)};
      res_nxt.blue = {hcd_nibble(store_nxt[4], 1'b0), hcd_nibble(store_nxt[5], 1'b0)};
      if (count_nxt == LEN_RRGGBBAA) begin
        res_nxt.alpha = {hcd_nibble(store_nxt[6], 1'b1), hcd_nibble(store_nxt[7], 1'b1)};
      end
    end
  end

  // Count register, cleared after a finishing item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (emit) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res = res_r;

endmodule

@@ rtl/core/hex_color_string_decoder.sv @@
// An accepted final item is written into the queue, then popped into the output register that drives out_valid.
// Throughput: one item per cycle while in_stall is low; a 2-entry queue parts the character front end
// from the digit store and decode, and the output register parts decode from out_stall.
// Reset: synchronous, active low; clears start flag, digit count, queue and output valid.
// The digit store is not reset; only digits written in the current string are read.
module hex_color_string_decoder import hcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_has_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha_out
);

  logic        acc;
  logic        push;
  hcd_entry_t  push_entry;
  logic        pop;
  logic        q_valid;
  hcd_entry_t  q_entry;
  logic        q_full;
  hcd_result_t res;

  assign in_stall = q_full;
  assign acc = in_valid && !in_stall;

  hcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .ch       (in_ch),
    .has_char (in_has_char),
    .last     (in_last),
    .push     (push),
    .entry    (push_entry)
  );

  hcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .full       (q_full)
  );

  hcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_ok = res.ok;
  assign out_red = res.red;
  assign out_green = res.green;
  assign out_blue = res.blue;
  assign out_alpha_out = res.alpha;

endmodule

@@ rtl/core/hcd_checker.sv @@
module hcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_ok,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha_out
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_alpha_out))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty string gives all-zero color
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_red == 8'h00 && out_green == 8'h00
      && out_blue == 8'h00 && out_alpha_out == 8'h00)
    else $error("empty string result not zero");

  // Input side is free after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind hex_color_string_decoder hcd_checker u_hcd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ok        (out_ok),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue),
  .out_alpha_out (out_alpha_out)
);

@@ test/hex_color_string_decoder_test.sv @@
`timescale 1ns / 100ps

module hex_color_string_decoder_test;
  import hcd_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = 8'h00;
  logic       in_has_char = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_ok;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha_out;

  // Predicted colors waiting for the decoder to deliver them
  hcd_result_t pending_colors[$];
  hcd_result_t want_color;
  hcd_result_t seen_color;

  // Shadow of the decoder's string state
  logic [3:0]  digit_total = '0;
  logic        awaiting_first = 1'b1;
  hcd_digit_t  digits[8];

  string hex_chars = "0123456789abcdefABCDEF";

  int idle_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int colors_checked = 0;
  int errors = 0;

  hex_color_string_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_has_char  (in_has_char),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha_out(out_alpha_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Classify one character: hex flag plus nibble value
  function automatic hcd_digit_t hex_value(input logic [7:0] c);
    hcd_digit_t d;
    d = '0;
    if (c >= "0" && c <= "9") begin
      d = {1'b1, c[3:0]};
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      d = {1'b1, c[3:0] + 4'd9};
    end
    return d;
  endfunction

  // Non-hex digits read as zero in a color and as full scale in alpha
  function automatic logic [3:0] digit_nibble(input int idx, input logic is_alpha);
    hcd_digit_t d;
    d = digits[idx];
    if (d.hex) begin
      return d.val;
    end
    return is_alpha ? NIB_FULL : NIB_ZERO;
  endfunction

  // Advance the shadow state by one accepted item; queue a color on the final one
  task automatic predict_color(input logic [7:0] ch, input logic has_char, input logic last);
    hcd_result_t color;
    if (has_char) begin
      if (!(awaiting_first && ch == CH_HASH)) begin
        if (digit_total < 4'd8) begin
          digits[digit_total[2:0]] = hex_value(ch);
        end
        if (digit_total != COUNT_MAX) begin
          digit_total = digit_total + 4'd1;
        end
      end
      awaiting_first = 1'b0;
    end
    if (last) begin
      color = '{ok: !awaiting_first, red: 8'h00, green: 8'h00, blue: 8'h00,
                alpha: ALPHA_OPAQUE};
      if (awaiting_first) begin
        color.alpha = 8'h00;
      end else begin
        case (digit_total)
          LEN_RGB, LEN_RGBA: begin
            color.red   = {2{digit_nibble(0, 1'b0)}};
            color.green = {2{digit_nibble(1, 1'b0)}};
            color.blue  = {2{digit_nibble(2, 1'b0)}};
            if (digit_total == LEN_RGBA) begin
              color.alpha = {2{digit_nibble(3, 1'b1)}};
            end
          end
          LEN_RRGGBB, LEN_RRGGBBAA: begin
            color.red   = {digit_nibble(0, 1'b0), digit_nibble(1, 1'b0)};
            color.green = {digit_nibble(2, 1'b0), digit_nibble(3, 1'b0)};
            color.blue  = {digit_nibble(4, 1'b0), digit_nibble(5, 1'b0)};
            if (digit_total == LEN_RRGGBBAA) begin
              color.alpha = {digit_nibble(6, 1'b1), digit_nibble(7, 1'b1)};
            end
          end
          default: ;
        endcase
      end
      pending_colors.push_back(color);
      digit_total = '0;
      awaiting_first = 1'b1;
    end
  endtask

  // Offer one item, optionally after an idle burst, and hold it until taken
  task automatic send_item(input logic [7:0] ch, input logic has_char, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_ch       <= ch;
    in_has_char <= has_char;
    in_last     <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_color(ch, has_char, last);
    if (has_char || last) begin
      items_sent++;
    end
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, close && i == s.len() - 1);
    end
  endtask

  // Drop valid and wait for every predicted color to come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_colors.size() != 0);
  endtask

  // One string: usually a valid color layout, sometimes odd lengths,
  // filler items, a closing item without a character, or raw bytes
  task automatic send_random_string(input bit noisy);
    int len;
    bit hashed;
    bit open_end;
    logic [7:0] ch;
    if (noisy || $urandom_range(0, 4) == 0) begin
      len = $urandom_range(0, 20);
    end else begin
      case ($urandom_range(0, 3))
        0: len = int'(LEN_RGB);
        1: len = int'(LEN_RGBA);
        2: len = int'(LEN_RRGGBB);
        default: len = int'(LEN_RRGGBBAA);
      endcase
    end
    hashed = $urandom_range(0, 9) < 8;
    open_end = $urandom_range(0, 11) == 0;
    if (len == 0 && !hashed) begin
      open_end = 1'b1;
    end
    if (hashed) begin
      send_item(CH_HASH, 1'b1, len == 0 && !open_end);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end
      if (noisy || $urandom_range(0, 11) == 0) begin
        ch = 8'($urandom);
      end else begin
        ch = hex_chars[$urandom_range(0, 21)];
      end
      send_item(ch, 1'b1, i == len - 1 && !open_end);
    end
    if (open_end) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic test_directed();
    idle_pct  <= 15;
    stall_pct <= 15;
    // empty string: end marker with no character
    send_item(8'h00, 1'b0, 1'b1);
    // bare hash gives opaque black
    send_text("#", 1'b1);
    // short form with mixed case
    send_text("#a0F", 1'b1);
    // hash past the first place in a color, non-hex in alpha
    send_text("f#9z", 1'b1);
    // filler item mid-string, closed by an end marker without a character
    send_text("#B", 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_text("c1234", 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // long form without hash, byte extremes in red and alpha
    send_item(8'h00, 1'b1, 1'b0);
    send_text("123456", 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
  endtask

  task automatic test_well_formed_strings(input int target);
    int first;
    int strings;
    first = items_sent;
    strings = 0;
    while (items_sent - first < target) begin
      if (strings % 12 == 0) begin
        idle_pct  <= $urandom_range(0, 3) * $urandom_range(0, 12);
        stall_pct <= $urandom_range(0, 3) * $urandom_range(0, 12);
      end
      // pause the sender until the decoder has caught up
      if (strings % 40 == 39) begin
        hold_until_drained();
      end
      send_random_string(1'b0);
      strings++;
    end
  endtask

  task automatic test_byte_noise(input int target);
    int first;
    first = items_sent;
    idle_pct  <= 10;
    stall_pct <= 10;
    while (items_sent - first < target) begin
      send_random_string(1'b1);
    end
  endtask

  // Back-to-back strings with no gaps on either side
  task automatic test_streaming(input int target);
    int first;
    first = items_sent;
    calm      <= 1'b1;
    idle_pct  <= 0;
    stall_pct <= 0;
    while (items_sent - first < target) begin
      send_random_string(1'b0);
    end
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check each delivered color against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_color = '{out_ok, out_red, out_green, out_blue, out_alpha_out};
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected color, expected none, got ok=%b rgba=%h",
                 $time, seen_color.ok, seen_color[31:0]);
        errors++;
      end else begin
        want_color = pending_colors.pop_front();
        compare_field("ok", 8'(want_color.ok), 8'(seen_color.ok));
        compare_field("red", want_color.red, seen_color.red);
        compare_field("green", want_color.green, seen_color.green);
        compare_field("blue", want_color.blue, seen_color.blue);
        compare_field("alpha", want_color.alpha, seen_color.alpha);
        colors_checked++;
      end
    end
  end

  // Count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_well_formed_strings(900);
    test_byte_noise(150);
    test_streaming(170);
    hold_until_drained();
    repeat (6) @(posedge clk);
    $display("Decoded %0d color strings from %0d items: empty, bare hash, short, long,",
             colors_checked, items_sent);
    $display("odd and saturated lengths, non-hex bytes, gaps and stalls, then a steady stream.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hcd_pkg.sv
rtl/core/hcd_front.sv
rtl/core/hcd_queue.sv
rtl/core/hcd_back.sv
rtl/core/hex_color_string_decoder.sv
rtl/core/hcd_checker.sv
test/hex_color_string_decoder_test.sv
